FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define AST_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: hdl/swmc_pkg.sv
// Package: controller commands, status and constants of the median cost unit.
package swmc_pkg;
   localparam int unsigned CFG_BITS    = 7;
   localparam int unsigned MEDIAN_BITS = 32;
   localparam int unsigned COST_BITS   = 39;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_WRITE = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_COST  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;      // capture input word, update ring
      logic scan_clr;  // clear rank scan
      logic scan_step; // one ring entry into rank counters
      logic cost_clr;
      logic cost_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic full;      // window holds enough samples
      logic scan_last;
      logic cost_last;
   } sts_type;
endpackage

FILE: hdl/swmc_ram.sv
// Generic single-port-write, one-read RAM with registered read.
module swmc_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

FILE: hdl/swmc_datapath.sv
// Datapath: arrival ring, median selection by rank scan, and cost accumulation.
module swmc_datapath import swmc_pkg::*; #(
   parameter int unsigned MAX_WINDOW  = 64,
   parameter int unsigned SAMPLE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output sts_type                      sts,
   input  logic [CFG_BITS-1:0]          win_len_cfg,
   input  logic signed [MEDIAN_BITS-1:0] in_sample,
   input  logic                         in_first,
   output logic signed [MEDIAN_BITS-1:0] out_median,
   output logic [COST_BITS-1:0]         out_cost
);
   localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
   localparam int unsigned SB = SAMPLE_BITS;
   localparam logic [COST_BITS:0] COST_SAT = {1'b0, {COST_BITS{1'b1}}};

   // Rank-based median: for each candidate c, count less-than and less-or-equal entries
   // over the window. Done as a two-level loop: outer candidate, inner entry.
   // Outer index and inner index walk the ring; one compare per cycle.
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] len;
   logic [CW-1:0] rank;          // target rank (len+1)/2-1
   logic [CW-1:0] oi_ff, oi_in;  // outer counter
   logic [CW-1:0] ii_ff, ii_in;  // inner counter
   logic [CW-1:0] lt_ff, lt_in, le_ff, le_in;
   logic signed [SB-1:0] med_ff, med_in;
   logic          found_ff, found_in;
   logic signed [SB-1:0] samp;
   logic [COST_BITS:0] acc_ff, acc_in;
   logic [SB:0]   diff;
   logic [AW-1:0] rd_a, rd_b, wr_a;
   logic signed [SB-1:0] rd_da, rd_db;
   logic          inner_last;

   // two read ports: two RAM copies written identically
   assign samp = SB'(in_sample);
   assign wr_a = (in_first) ? '0 : ptr_ff;

   swmc_ram #(.WIDTH(SB), .DEPTH(MAX_WINDOW)) u_ram_a (
      .clock(clock), .wr_en(cmd.load), .wr_addr(wr_a), .wr_data(samp),
      .rd_addr(rd_a), .rd_data(rd_da));
   swmc_ram #(.WIDTH(SB), .DEPTH(MAX_WINDOW)) u_ram_b (
      .clock(clock), .wr_en(cmd.load), .wr_addr(wr_a), .wr_data(samp),
      .rd_addr(rd_b), .rd_data(rd_db));

   always_comb begin
      if (win_len_cfg == '0) begin
         len = CW'(1);
      end else if (int'(win_len_cfg) > int'(MAX_WINDOW)) begin
         len = CW'(MAX_WINDOW);
      end else begin
         len = CW'(win_len_cfg);
      end
      rank = CW'(({1'b0, len} + (CW+1)'(1)) >> 1) - CW'(1);
   end

   // ring address of k-th newest entry (k from 0): ptr-1-k, wrapped once
   function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] p, input logic [CW-1:0] k);
      int t;
      t = int'(p) - int'(k) - 1;
      if (t < 0) t = t + int'(MAX_WINDOW);
      ring_addr = AW'(t);
   endfunction

   assign rd_a = ring_addr(ptr_ff, oi_in);
   assign rd_b = ring_addr(ptr_ff, ii_in);
   assign inner_last = (ii_ff == len - CW'(1));

   always_comb begin
      ptr_in   = ptr_ff;
      fill_in  = fill_ff;
      oi_in    = oi_ff;
      ii_in    = ii_ff;
      lt_in    = lt_ff;
      le_in    = le_ff;
      med_in   = med_ff;
      found_in = found_ff;
      acc_in   = acc_ff;
      diff     = '0;
      if (cmd.load) begin
         ptr_in  = (MAX_WINDOW == 1 || wr_a == AW'(MAX_WINDOW - 1)) ? '0 : wr_a + AW'(1);
         fill_in = in_first ? CW'(1)
                 : ((fill_ff < CW'(MAX_WINDOW)) ? fill_ff + CW'(1) : fill_ff);
      end
      if (cmd.scan_clr) begin
         oi_in = '0; ii_in = '0; lt_in = '0; le_in = '0; found_in = 1'b0;
      end
      if (cmd.scan_step) begin
         // rd_da holds candidate oi_ff, rd_db holds entry ii_ff (registered RAM read)
         lt_in = lt_ff + CW'(rd_db < rd_da);
         le_in = le_ff + CW'(rd_db <= rd_da);
         if (inner_last) begin
            if (!found_ff && lt_in <= rank && le_in > rank) begin
               found_in = 1'b1;
               med_in   = rd_da;
            end
            oi_in = oi_ff + CW'(1);
            ii_in = '0;
            lt_in = '0;
            le_in = '0;
         end else begin
            ii_in = ii_ff + CW'(1);
         end
      end
      if (cmd.cost_clr) begin
         ii_in = '0; acc_in = '0;
      end
      if (cmd.cost_step) begin
         diff = (rd_db >= med_ff) ? (SB+1)'($signed({rd_db[SB-1], rd_db}) - $signed({med_ff[SB-1], med_ff}))
                                  : (SB+1)'($signed({med_ff[SB-1], med_ff}) - $signed({rd_db[SB-1], rd_db}));
         acc_in = acc_ff + (COST_BITS+1)'(diff);
         if (acc_in > COST_SAT) acc_in = COST_SAT;
         ii_in = ii_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         fill_ff <= '0;
      end else begin
         ptr_ff  <= ptr_in;
         fill_ff <= fill_in;
      end
      oi_ff    <= oi_in;
      ii_ff    <= ii_in;
      lt_ff    <= lt_in;
      le_ff    <= le_in;
      med_ff   <= med_in;
      found_ff <= found_in;
      acc_ff   <= acc_in;
      if (cmd.out_load) begin
         out_median <= MEDIAN_BITS'(med_ff);
         out_cost   <= acc_ff[COST_BITS-1:0];
      end
   end

   assign sts.full      = (fill_ff >= len);
   assign sts.scan_last = inner_last && (oi_ff == len - CW'(1));
   assign sts.cost_last = (ii_ff == len - CW'(1));
endmodule

FILE: hdl/swmc_ctrl.sv
// Controller: sequences load, median rank scan, cost sum and result word.
module swmc_ctrl import swmc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd,
   output state_type state
);
   state_type state_ff, state_in;
   logic vld_ff, vld_in;
   logic prime_ff, prime_in; // first cycle of a phase: RAM read latency

   assign state = state_ff;
   assign rsp_valid = vld_ff;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      vld_in   = vld_ff && rsp_stall;
      prime_in = 1'b0;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (!sts.full) begin
               state_in = ST_IDLE;
            end else begin
               cmd.scan_clr = 1'b1;
               prime_in = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (prime_ff) begin
               cmd.scan_step = 1'b0;
            end else begin
               cmd.scan_step = 1'b1;
               if (sts.scan_last) begin
                  cmd.cost_clr = 1'b1;
                  prime_in = 1'b1;
                  state_in = ST_COST;
               end
            end
         end
         ST_COST: begin
            if (!prime_ff) begin
               cmd.cost_step = 1'b1;
               if (sts.cost_last) begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!vld_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               vld_in   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
         prime_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         prime_ff <= prime_in;
      end
   end
endmodule

FILE: hdl/sliding_window_median_cost_unit.sv
// Top level of the sliding window median cost unit.
//  channel | direction | ports
//  req     | in        | req_valid, req_stall, req_sample, req_first
//  rsp     | out       | rsp_valid, rsp_stall, rsp_median, rsp_cost
//  csr     | in        | csr_wr_en, csr_wr_data (window_len)
// A word that does not fill the window returns to idle without a result. For a
// full window the median is found by ranking each window entry against every
// entry, one compare per cycle on two RAM read ports.
// Reset is synchronous and clears the controller, fill count and ring pointer.
// rsp holds its word while stalled; a new result waits for it to go out, and
// the next req word is taken once that result sits in the output register.
`include "assert_macros.svh"
module sliding_window_median_cost_unit import swmc_pkg::*; #(
   parameter int unsigned MAX_WINDOW  = 64,
   parameter int unsigned SAMPLE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [MEDIAN_BITS-1:0]  req_sample,
   input  logic                           req_first,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [MEDIAN_BITS-1:0]  rsp_median,
   output logic [COST_BITS-1:0]           rsp_cost,
   input  logic                           csr_wr_en,
   input  logic [CFG_BITS-1:0]            csr_wr_data
);
   logic [CFG_BITS-1:0] win_len_ff;
   cmd_type   cmd;
   sts_type   sts;
   state_type state;
   logic signed [MEDIAN_BITS-1:0] med_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff <= CFG_BITS'(1);
      end else if (csr_wr_en) begin
         win_len_ff <= csr_wr_data;
      end
   end

   swmc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd), .state(state));

   swmc_datapath #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .win_len_cfg(win_len_ff),
      .in_sample(req_sample), .in_first(req_first), .out_median(med_raw),
      .out_cost(rsp_cost));

   assign rsp_median = med_raw;

   `AST_IMPL(a_stall_busy, clock, reset, state != ST_IDLE, req_stall)
   `AST_NEXT(a_load_leaves_idle, clock, reset, req_valid && !req_stall, state == ST_WRITE)
   `AST_IMPL(a_out_single, clock, reset, cmd.out_load, state == ST_OUT)
endmodule
